FILE: src/lorff_pkg.sv
`timescale 1ns / 1ps

package lorff_pkg;

  // Default store geometry.
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  // Field widths of the request and result items.
  localparam int CMD_W  = 1;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 5;
  localparam int VAL_W  = 8;
  localparam int OUT_W  = 11;
  localparam int OUT_MAX = 2047;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes).
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0]  REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_COLS_IN_USE = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET = 6'd32;

  // Request kinds carried on tuser.
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 1'b1;

  // Neighbor visiting order around a dequeued cell.
  localparam logic [1:0] NB_DOWN  = 2'd0;
  localparam logic [1:0] NB_UP    = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_LEFT  = 2'd3;

  typedef struct packed {
    logic       load_cell;
    logic       run_start;
    logic       clr_step;
    logic       land_rd;
    logic       land_cap;
    logic       seed;
    logic       seed_scan;
    logic       pop_rd;
    logic       pop_cap;
    logic       nb_ev;
    logic [1:0] nb_sel;
    logic       best_upd;
    logic       scan_rd;
    logic       scan_adv;
    logic       out_load;
  } lorff_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic clr_done;
    logic q_empty;
    logic nb_ok;
    logic free_land;
    logic scan_done;
    logic out_busy;
  } lorff_status_t;

endpackage

FILE: src/lorff_ram.sv
`timescale 1ns / 1ps

module lorff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/lorff_ctrl.sv
`timescale 1ns / 1ps

module lorff_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic [lorff_pkg::CMD_W-1:0]    in_command,
  output logic                           in_tready,
  output lorff_pkg::lorff_cmd_t          cmd,
  input  lorff_pkg::lorff_status_t       sts
);

  import lorff_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHK     = 4'd1;
  localparam logic [3:0] S_CLR     = 4'd2;
  localparam logic [3:0] S_LAND_RD = 4'd3;
  localparam logic [3:0] S_LAND_WT = 4'd4;
  localparam logic [3:0] S_POP_RD  = 4'd5;
  localparam logic [3:0] S_POP_WT  = 4'd6;
  localparam logic [3:0] S_NB_RD   = 4'd7;
  localparam logic [3:0] S_NB_EV   = 4'd8;
  localparam logic [3:0] S_SCAN_RD = 4'd9;
  localparam logic [3:0] S_SCAN_EV = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] nb_r, nb_nxt;
  // Set while the start region is being flooded; its size is not ranked.
  logic       first_r, first_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    nb_nxt    = nb_r;
    first_nxt = first_r;
    cmd       = '0;
    cmd.nb_sel = nb_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_RUN) begin
            cmd.run_start = 1'b1;
            state_nxt     = S_CHK;
          end else begin
            cmd.load_cell = 1'b1;
          end
        end
      end
      S_CHK: begin
        state_nxt = sts.start_ok ? S_CLR : S_DONE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_LAND_RD;
        end
      end
      S_LAND_RD: begin
        cmd.land_rd = 1'b1;
        state_nxt   = S_LAND_WT;
      end
      S_LAND_WT: begin
        cmd.land_cap = 1'b1;
        cmd.seed     = 1'b1;
        first_nxt    = 1'b1;
        state_nxt    = S_POP_RD;
      end
      S_POP_RD: begin
        if (sts.q_empty) begin
          cmd.best_upd = !first_r;
          first_nxt    = 1'b0;
          state_nxt    = S_SCAN_RD;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP_WT;
        end
      end
      S_POP_WT: begin
        cmd.pop_cap = 1'b1;
        nb_nxt      = NB_DOWN;
        state_nxt   = S_NB_RD;
      end
      S_NB_RD: begin
        if (sts.nb_ok) begin
          state_nxt = S_NB_EV;
        end else if (nb_r == NB_LEFT) begin
          state_nxt = S_POP_RD;
        end else begin
          nb_nxt = nb_r + 2'd1;
        end
      end
      S_NB_EV: begin
        cmd.nb_ev = 1'b1;
        if (nb_r == NB_LEFT) begin
          state_nxt = S_POP_RD;
        end else begin
          nb_nxt    = nb_r + 2'd1;
          state_nxt = S_NB_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd.scan_adv = 1'b1;
        if (sts.free_land) begin
          cmd.seed      = 1'b1;
          cmd.seed_scan = 1'b1;
          state_nxt     = S_POP_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nb_r    <= NB_DOWN;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nb_r    <= nb_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

FILE: src/lorff_dp.sv
`timescale 1ns / 1ps

module lorff_dp #(
  parameter int MAX_ROWS = lorff_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lorff_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lorff_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lorff_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [lorff_pkg::ROW_W-1:0]       in_row,
  input  logic [lorff_pkg::COL_W-1:0]       in_col,
  input  logic [lorff_pkg::VAL_W-1:0]       in_cell_value,
  input  logic                              out_tready,
  output logic                              out_valid,
  output logic [lorff_pkg::OUT_W-1:0]       out_largest_region,
  input  lorff_pkg::lorff_cmd_t             cmd,
  output lorff_pkg::lorff_status_t          sts
);

  import lorff_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int QW    = RW + CW;
  localparam int QCW   = $clog2(CELLS + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
  endfunction

  // Configuration.
  logic [CFG_DATA_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [CFG_DATA_W-1:0] cols_cfg_r, cols_cfg_nxt;

  // Run state.
  logic [NRW-1:0]   nr_r, nr_nxt;
  logic [NCW-1:0]   nc_r, nc_nxt;
  logic [ROW_W-1:0] start_r_r, start_r_nxt;
  logic [COL_W-1:0] start_c_r, start_c_nxt;
  logic [VAL_W-1:0] land_r, land_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [QCW-1:0]   head_r, head_nxt;
  logic [QCW-1:0]   tail_r, tail_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic [QCW-1:0]   best_r, best_nxt;
  logic [RW-1:0]    cur_r_r, cur_r_nxt;
  logic [CW-1:0]    cur_c_r, cur_c_nxt;
  logic [NRW-1:0]   scan_r_r, scan_r_nxt;
  logic [CW-1:0]    scan_c_r, scan_c_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // Neighbor and seed coordinates.
  logic [RW-1:0] nb_row, seed_row;
  logic [CW-1:0] nb_col, seed_col;
  logic          nb_ok;
  logic          push;

  // Memory ports.
  logic          g_we;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [VAL_W-1:0] g_rdata;
  logic          v_we;
  logic [AW-1:0] v_waddr, v_raddr;
  logic          v_wdata, v_rdata;
  logic          q_we;
  logic [AW-1:0] q_waddr;
  logic [QW-1:0] q_wdata, q_rdata;

  lorff_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (in_cell_value),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  lorff_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  lorff_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (q_rdata)
  );

  // Neighbor of the dequeued cell selected by the controller.
  always_comb begin
    nb_row = cur_r_r;
    nb_col = cur_c_r;
    unique case (cmd.nb_sel)
      NB_DOWN: begin
        nb_row = cur_r_r + RW'(1);
        nb_ok  = (32'(cur_r_r) + 32'd1) < 32'(nr_r);
      end
      NB_UP: begin
        nb_row = cur_r_r - RW'(1);
        nb_ok  = (cur_r_r != '0);
      end
      NB_RIGHT: begin
        nb_col = cur_c_r + CW'(1);
        nb_ok  = (32'(cur_c_r) + 32'd1) < 32'(nc_r);
      end
      NB_LEFT: begin
        nb_col = cur_c_r - CW'(1);
        nb_ok  = (cur_c_r != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign seed_row = cmd.seed_scan ? RW'(scan_r_r) : RW'(start_r_r);
  assign seed_col = cmd.seed_scan ? scan_c_r : CW'(start_c_r);

  assign sts.free_land = !v_rdata && (g_rdata == land_r);
  assign push          = cmd.nb_ev && sts.free_land;

  // Grid store: written by load requests, read by the search.
  assign g_we = cmd.load_cell && (32'(in_row) < 32'(MAX_ROWS)) &&
                (32'(in_col) < 32'(MAX_COLS));
  assign g_waddr = cell_addr(RW'(in_row), CW'(in_col));

  always_comb begin
    priority if (cmd.land_rd) begin
      g_raddr = cell_addr(RW'(start_r_r), CW'(start_c_r));
    end else if (cmd.scan_rd) begin
      g_raddr = cell_addr(RW'(scan_r_r), scan_c_r);
    end else begin
      g_raddr = cell_addr(nb_row, nb_col);
    end
  end

  assign v_raddr = cmd.scan_rd ? cell_addr(RW'(scan_r_r), scan_c_r) : cell_addr(nb_row, nb_col);

  always_comb begin
    v_we    = cmd.clr_step || cmd.seed || push;
    v_wdata = !cmd.clr_step;
    priority if (cmd.clr_step) begin
      v_waddr = clr_r;
    end else if (cmd.seed) begin
      v_waddr = cell_addr(seed_row, seed_col);
    end else begin
      v_waddr = cell_addr(nb_row, nb_col);
    end
  end

  assign q_we    = cmd.seed || push;
  assign q_waddr = cmd.seed ? '0 : tail_r[AW-1:0];
  assign q_wdata = cmd.seed ? {seed_row, seed_col} : {nb_row, nb_col};

  always_comb begin
    rows_cfg_nxt  = rows_cfg_r;
    cols_cfg_nxt  = cols_cfg_r;
    nr_nxt        = nr_r;
    nc_nxt        = nc_r;
    start_r_nxt   = start_r_r;
    start_c_nxt   = start_c_r;
    land_nxt      = land_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    cur_r_nxt     = cur_r_r;
    cur_c_nxt     = cur_c_r;
    scan_r_nxt    = scan_r_r;
    scan_c_nxt    = scan_c_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE: rows_cfg_nxt = cfg_wdata;
        REG_COLS_IN_USE: cols_cfg_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (cmd.run_start) begin
      nr_nxt      = (32'(rows_cfg_r) > 32'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_cfg_r);
      nc_nxt      = (32'(cols_cfg_r) > 32'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_cfg_r);
      start_r_nxt = in_row;
      start_c_nxt = in_col;
      clr_nxt     = '0;
      best_nxt    = '0;
      scan_r_nxt  = '0;
      scan_c_nxt  = '0;
    end
    if (cmd.clr_step) begin
      clr_nxt = clr_r + AW'(1);
    end
    if (cmd.land_cap) begin
      land_nxt = g_rdata;
    end
    if (cmd.seed) begin
      head_nxt  = '0;
      tail_nxt  = QCW'(1);
      count_nxt = '0;
    end
    if (cmd.pop_rd) begin
      head_nxt  = head_r + QCW'(1);
      count_nxt = count_r + QCW'(1);
    end
    if (cmd.pop_cap) begin
      cur_r_nxt = q_rdata[QW-1:CW];
      cur_c_nxt = q_rdata[CW-1:0];
    end
    if (push) begin
      tail_nxt = tail_r + QCW'(1);
    end
    if (cmd.best_upd && (count_r > best_r)) begin
      best_nxt = count_r;
    end
    if (cmd.scan_adv) begin
      if ((32'(scan_c_r) + 32'd1) == 32'(nc_r)) begin
        scan_c_nxt = '0;
        scan_r_nxt = scan_r_r + NRW'(1);
      end else begin
        scan_c_nxt = scan_c_r + CW'(1);
      end
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (32'(best_r) > 32'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(best_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= ROWS_RESET;
      cols_cfg_r  <= COLS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nr_r       <= nr_nxt;
    nc_r       <= nc_nxt;
    start_r_r  <= start_r_nxt;
    start_c_r  <= start_c_nxt;
    land_r     <= land_nxt;
    clr_r      <= clr_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    count_r    <= count_nxt;
    best_r     <= best_nxt;
    cur_r_r    <= cur_r_nxt;
    cur_c_r    <= cur_c_nxt;
    scan_r_r   <= scan_r_nxt;
    scan_c_r   <= scan_c_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.start_ok  = (32'(start_r_r) < 32'(nr_r)) && (32'(start_c_r) < 32'(nc_r));
  assign sts.clr_done  = (clr_r == AW'(CELLS - 1));
  assign sts.q_empty   = (head_r == tail_r);
  assign sts.nb_ok     = nb_ok;
  assign sts.scan_done = (scan_r_r == nr_r);
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign out_valid          = out_valid_r;
  assign out_largest_region = out_data_r;

endmodule

FILE: src/largest_other_region_flood_fill_core.sv
`timescale 1ns / 1ps

// Largest-other-region flood fill over a character grid.
//
// Input stream: each request carries its command on in_tuser. A write request
// stores in_tdata's cell value at (row, col) while the controller stays idle,
// so cell loads stream in back to back. A run request takes the symbol at the
// start cell as land, floods the start region to exclude it, then scans the
// in-use area and floods every other land region. Each run leaves exactly one
// result, the largest such region size (saturating at 2047); writes give none.
// A run holds in_tready low until its result is in the output register. It
// first clears the whole visited map, one cell at a time, through its single
// write port. It then reads and evaluates each in-area cell in the scan, and
// for each flooded cell pops it from the queue and reads each neighbor,
// evaluating those that lie inside the area.
// The result register frees the input side: writes keep flowing while a result
// waits, and a following run waits at its end for the output to drain when
// the receiver stalls.
// Reset (rst_n, synchronous) empties the output and sets both area registers
// to 32; the grid is undefined until written. Configure only between runs.
module largest_other_region_flood_fill_core #(
  parameter int MAX_ROWS = lorff_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = lorff_pkg::DEF_MAX_COLS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port: index 0 rows_in_use, index 1 cols_in_use.
  input  logic                               cfg_we,
  input  logic [lorff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lorff_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Request stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: row [4:0], col [9:5], cell_value [17:10], zero [23:18].
  input  logic [lorff_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: command [0] (0 writes a cell, 1 runs the search).
  input  logic [lorff_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: largest_region [10:0], zero [15:11].
  output logic [lorff_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import lorff_pkg::*;

  lorff_cmd_t    cmd;
  lorff_status_t sts;
  logic [OUT_W-1:0] largest_region;

  // The controller sequences clearing, flooding and scanning; the datapath
  // owns the grid, visited and queue memories and all counters.
  lorff_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser[CMD_W-1:0]),
    .in_tready  (in_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  lorff_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_row             (in_tdata[ROW_W-1:0]),
    .in_col             (in_tdata[ROW_W+COL_W-1:ROW_W]),
    .in_cell_value      (in_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W]),
    .out_tready         (out_tready),
    .out_valid          (out_tvalid),
    .out_largest_region (largest_region),
    .cmd                (cmd),
    .sts                (sts)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, largest_region};

endmodule

FILE: bench/tb_largest_other_region_flood_fill_core.sv
`timescale 1ns / 1ps

// The bench streams cell writes and region searches into the flood-fill core.
// It keeps its own image of the grid and answers every accepted search with
// a breadth-first count of its own. Each returned size is then compared with
// the oldest outstanding answer.
module tb_largest_other_region_flood_fill_core;
  import lorff_pkg::*;

  localparam int MAX_R = DEF_MAX_ROWS;
  localparam int MAX_C = DEF_MAX_COLS;
  localparam int CELLS = MAX_R * MAX_C;

  // A full 32x32 search clears the whole visited map and then scans and
  // floods every land cell, all with no handshake at all. Add the receiver's
  // longest stall and the forced hold, then allow about five times that.
  localparam int STALL_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 6000;
  // Only a cell write can still be in flight once the last answer is back,
  // and a write retires as soon as it is accepted.
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_PHASES   = 11;
  localparam int PRESSURE_PHASE = 1;

  typedef struct packed {
    logic [CMD_W-1:0] kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = CMD_WRITE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  largest_other_region_flood_fill_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Requests waiting for the driver, and region sizes waiting for the core.
  request_t request_fifo[$];
  logic [OUT_W-1:0] expected_region_sizes[$];
  request_t active_req;

  // The bench's own copy of the grid, the visited marks of one search and
  // the area registers as last written.
  bit [VAL_W-1:0] grid_img [CELLS];
  bit seen_map [CELLS];
  int area_rows = 32;
  int area_cols = 32;

  // Idling percentages and the one-shot request for a long receiver hold.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  int quiet_cycles = 0;
  int requests_accepted = 0;
  int runs_accepted = 0;
  int sizes_checked = 0;
  int mismatch_count = 0;
  int area_settings = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Area registers above the store size are clamped to the store.
  function automatic int active_rows();
    return (area_rows > MAX_R) ? MAX_R : area_rows;
  endfunction

  function automatic int active_cols();
    return (area_cols > MAX_C) ? MAX_C : area_cols;
  endfunction

  // Marks a neighbor as visited when it lies inside the area, is unvisited
  // and carries the land symbol. Returns whether it joined the region.
  function automatic bit claim_cell(int r, int c, int nr, int nc, bit [VAL_W-1:0] land);
    int idx;
    if (r >= nr || c >= nc) return 1'b0;
    idx = r * MAX_C + c;
    if (seen_map[idx] || grid_img[idx] != land) return 1'b0;
    seen_map[idx] = 1'b1;
    return 1'b1;
  endfunction

  // Breadth-first flood from one seed cell; returns the region size.
  function automatic int flood_size(int r0, int c0, int nr, int nc, bit [VAL_W-1:0] land);
    int frontier[$];
    int idx;
    int r;
    int c;
    int size;
    size = 0;
    seen_map[r0 * MAX_C + c0] = 1'b1;
    frontier.insert(frontier.size(), r0 * MAX_C + c0);
    while (frontier.size() > 0) begin
      idx = frontier.pop_front();
      r = idx / MAX_C;
      c = idx % MAX_C;
      size++;
      // Up, down, left and right only; no wrap at any edge.
      if (claim_cell(r + 1, c, nr, nc, land)) frontier.insert(frontier.size(), idx + MAX_C);
      if (r > 0) begin
        if (claim_cell(r - 1, c, nr, nc, land)) frontier.insert(frontier.size(), idx - MAX_C);
      end
      if (claim_cell(r, c + 1, nr, nc, land)) frontier.insert(frontier.size(), idx + 1);
      if (c > 0) begin
        if (claim_cell(r, c - 1, nr, nc, land)) frontier.insert(frontier.size(), idx - 1);
      end
    end
    return size;
  endfunction

  // Size of the largest region of the start cell's symbol, leaving out the
  // start cell's own region. A start outside the area answers zero.
  function automatic logic [OUT_W-1:0] largest_other_region(int r0, int c0);
    int nr;
    int nc;
    int best;
    int size;
    bit [VAL_W-1:0] land;
    nr = active_rows();
    nc = active_cols();
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    best = 0;
    if (r0 < nr && c0 < nc) begin
      land = grid_img[r0 * MAX_C + c0];
      size = flood_size(r0, c0, nr, nc, land);
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          if (!seen_map[r * MAX_C + c] && grid_img[r * MAX_C + c] == land) begin
            size = flood_size(r, c, nr, nc, land);
            if (size > best) best = size;
          end
        end
      end
    end
    return (best > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(best);
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  // The driver presents the head of the request queue. On acceptance the
  // grid image is updated for a write, and a search gets its answer worked
  // out against the grid as it stands at that moment.
  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        requests_accepted++;
        if (active_req.kind == CMD_RUN) begin
          runs_accepted++;
          expected_region_sizes.insert(expected_region_sizes.size(),
            largest_other_region(int'(active_req.row), int'(active_req.col)));
        end else begin
          // Five-bit coordinates never leave the 32x32 store, so every write lands.
          grid_img[int'(active_req.row) * MAX_C + int'(active_req.col)] = active_req.value;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (request_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          active_req = request_fifo.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_TDATA_W - ROW_W - COL_W - VAL_W){1'b0}},
                        active_req.value, active_req.col, active_req.row};
          in_tuser  <= active_req.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The receiver stalls at random, except during the long hold, which it
  // counts down itself while the sender keeps offering requests.
  always @(posedge clk) begin : result_receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_checker
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_region_sizes.size() == 0) begin
        note_mismatch($sformatf("region size %0d arrived with no search outstanding",
                                out_tdata[OUT_W-1:0]));
      end else begin
        want = expected_region_sizes.pop_front();
        sizes_checked++;
        if (out_tdata !== OUT_TDATA_W'(want)) begin
          note_mismatch($sformatf("search %0d: expected size %0d, got %0d (tdata 0x%h)",
                                  sizes_checked, want, out_tdata[OUT_W-1:0], out_tdata));
        end
      end
    end
  end

  // Counts cycles in which neither side completes a handshake.
  always @(posedge clk) begin : quiet_counter
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Run stalled for %0d cycles with %0d region sizes still outstanding.",
             STALL_LIMIT, expected_region_sizes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Area writes happen only while the core is idle. The bench's copy of the
  // registers changes along with them; nothing is in flight at that point.
  task automatic set_area(input int rows, input int cols);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_wdata <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_index <= REG_COLS_IN_USE;
    cfg_wdata <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_we <= 1'b0;
    area_rows = rows;
    area_cols = cols;
    area_settings++;
    @(negedge clk);
  endtask

  function automatic void queue_request(logic [CMD_W-1:0] kind, int row, int col, int value);
    request_t req;
    req.kind  = kind;
    req.row   = ROW_W'(row);
    req.col   = COL_W'(col);
    req.value = VAL_W'(value);
    request_fifo.insert(request_fifo.size(), req);
  endfunction

  // Waits until every request is taken and every answer has come back, then
  // gives a trailing write time to retire.
  task automatic drain_core();
    while (request_fifo.size() > 0 || in_tvalid || expected_region_sizes.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Most writes paint the current area from a small alphabet, so regions of
  // every shape form; most searches start inside the area. The rest is noise:
  // any cell, any byte, and starts anywhere in the store.
  task automatic fill_random(input int count, input int run_pct, input int run_cap);
    bit [VAL_W-1:0] symbols[3];
    int n_symbols;
    int nr;
    int nc;
    int runs;
    nr = active_rows();
    nc = active_cols();
    n_symbols = $urandom_range(3, 2);
    foreach (symbols[k]) symbols[k] = VAL_W'($urandom_range(255));
    runs = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < run_pct && runs < run_cap) begin
        runs++;
        if (nr > 0 && nc > 0 && $urandom_range(99) < 85) begin
          queue_request(CMD_RUN, $urandom_range(nr - 1), $urandom_range(nc - 1), 0);
        end else begin
          queue_request(CMD_RUN, $urandom_range(31), $urandom_range(31), $urandom_range(255));
        end
      end else if (nr > 0 && nc > 0 && $urandom_range(99) < 85) begin
        queue_request(CMD_WRITE, $urandom_range(nr - 1), $urandom_range(nc - 1),
                      symbols[$urandom_range(n_symbols - 1)]);
      end else begin
        queue_request(CMD_WRITE, $urandom_range(31), $urandom_range(31), $urandom_range(255));
      end
    end
  endtask

  initial begin : sequencer
    // Directed map on a 3x4 area, 1 meaning 8'hFF and 0 meaning 8'h00:
    //   0 0 1 0
    //   1 1 1 0
    //   0 1 0 0
    bit [11:0] directed_map;
    bit [VAL_W-1:0] sym_a;
    bit [VAL_W-1:0] sym_b;
    int rows;
    int cols;
    int run_pct;
    int run_cap;
    directed_map = 12'h274;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: both symbol extremes, a search whose symbol forms one
    // region only, writes kept outside the area, and starts past each edge.
    set_area(3, 4);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        queue_request(CMD_WRITE, r, c, directed_map[r * 4 + c] ? 8'hFF : 8'h00);
      end
    end
    queue_request(CMD_WRITE, 31, 31, 8'hAA);
    queue_request(CMD_WRITE, 3, 0, 8'h00);
    queue_request(CMD_RUN, 0, 0, 0);
    queue_request(CMD_RUN, 1, 0, 0);
    queue_request(CMD_RUN, 2, 3, 0);
    queue_request(CMD_RUN, 3, 0, 0);
    queue_request(CMD_RUN, 0, 4, 0);
    queue_request(CMD_RUN, 31, 31, 8'hFF);
    drain_core();

    // An empty area answers zero without touching the grid.
    set_area(0, 4);
    queue_request(CMD_RUN, 0, 0, 0);
    drain_core();

    // A single-cell area: the start region is the whole map.
    set_area(1, 1);
    queue_request(CMD_RUN, 0, 0, 0);
    queue_request(CMD_RUN, 0, 1, 0);
    drain_core();

    // Load the whole store with a two-symbol map so that any later area is
    // fully written, then search it at full size.
    set_area(32, 32);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    sym_a = VAL_W'($urandom_range(255));
    sym_b = ~sym_a;
    for (int r = 0; r < MAX_R; r++) begin
      for (int c = 0; c < MAX_C; c++) begin
        if ($urandom_range(99) < 5)
          queue_request(CMD_WRITE, r, c, $urandom_range(255));
        else
          queue_request(CMD_WRITE, r, c, ($urandom_range(99) < 55) ? sym_a : sym_b);
      end
    end
    for (int k = 0; k < 3; k++) queue_request(CMD_RUN, $urandom_range(31), $urandom_range(31), 0);
    drain_core();

    // Mixed phases over a spread of areas, including clamped and empty ones,
    // cycling through the four handshake patterns.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin rows = 1;  cols = 1;  end
        1:       begin rows = 2;  cols = 2;  end
        2:       begin rows = 4;  cols = 7;  end
        3:       begin rows = 32; cols = 1;  end
        4:       begin rows = 1;  cols = 32; end
        5:       begin rows = 63; cols = 40; end
        6:       begin rows = 0;  cols = 9;  end
        7:       begin rows = 5;  cols = 3;  end
        8:       begin rows = 33; cols = 2;  end
        9:       begin rows = 8;  cols = 8;  end
        default: begin rows = 6;  cols = 5;  end
      endcase
      set_area(rows, cols);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      // Searches cost time in proportion to the area, so large areas get
      // only a couple of them.
      if (active_rows() * active_cols() <= 16) run_pct = 40;
      else if (active_rows() * active_cols() <= 64) run_pct = 25;
      else run_pct = 5;
      run_cap = (active_rows() * active_cols() > 64) ? 2 : 1000;
      if (p == PRESSURE_PHASE) begin
        // Searches back to back against a receiver that holds off: the
        // result register fills, a second search finishes behind it, and
        // the core has to stall its input.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_pct = 70;
        hold_pending = 1'b1;
      end
      fill_random(46, run_pct, run_cap);
      drain_core();
    end

    $display("Covered %0d requests, %0d of them region searches, over %0d area settings.",
             requests_accepted, runs_accepted, area_settings);
    $display("Compared %0d region sizes; %0d mismatches.", sizes_checked, mismatch_count);
    if (mismatch_count == 0 && expected_region_sizes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
